### rtl/core/gswu_pkg.sv
// Shared types, codes and constants for the Gaussian-window STDP weight update core.
// No dependencies; every other file but gswu_fifo refers to it by scoped names.
package gswu_pkg;

  // weight bounds (Q1.14)
  localparam int W_MAX = 32768;

  // datapath widths
  localparam int EXPY_W = 26;   // exponent argument, Q16 signed
  localparam int EXPV_W = 33;   // exponent result, Q16 unsigned, up to 2^32
  localparam int SQ_W   = 38;   // squared distance below the cutoff
  localparam int DEN_W  = 33;   // 2*sigma^2
  localparam int Q_W    = 21;   // quotient bits of the Gaussian argument

  // input action codes
  localparam logic [1:0] ACT_LTP  = 2'd0;
  localparam logic [1:0] ACT_LTD  = 2'd1;
  localparam logic [1:0] ACT_LOAD = 2'd2;

  // configuration register indexes (byte address / 4)
  localparam logic [2:0] REG_LTP_MEAN  = 3'd0;
  localparam logic [2:0] REG_LTP_WIDTH = 3'd1;
  localparam logic [2:0] REG_LTP_RATE  = 3'd2;
  localparam logic [2:0] REG_LTD_MEAN  = 3'd3;
  localparam logic [2:0] REG_LTD_WIDTH = 3'd4;
  localparam logic [2:0] REG_LTD_RATE  = 3'd5;
  localparam logic [2:0] REG_LTP_GAIN  = 3'd6;
  localparam logic [2:0] REG_LTD_GAIN  = 3'd7;

  // classified operation codes
  typedef logic [2:0] op_t;
  localparam op_t OP_LTP  = 3'd0;
  localparam op_t OP_LTD  = 3'd1;
  localparam op_t OP_LOAD = 3'd2;
  localparam op_t OP_KEEP = 3'd3;
  localparam op_t OP_SKIP = 3'd4;

  // item passed from front to back
  typedef struct packed {
    op_t                op;
    logic [7:0]         idx;
    logic signed [15:0] theta;
    logic signed [32:0] dt;
    logic [15:0]        load;
  } item_t;

  // configuration registers
  typedef struct packed {
    logic [15:0] ltp_mean;
    logic [15:0] ltp_width;
    logic [15:0] ltp_rate;
    logic [15:0] ltd_mean;
    logic [15:0] ltd_width;
    logic [15:0] ltd_rate;
    logic [15:0] ltp_gain;
    logic [15:0] ltd_gain;
  } cfg_t;

  // result item
  typedef struct packed {
    logic [7:0]  idx;
    logic [15:0] weight;
    logic [23:0] total;
  } res_t;

  // 2^(j/16) in Q16
  function automatic logic [17:0] pow2_frac(input logic [4:0] j);
    logic [17:0] v;
    case (j)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115098;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/gswu_fifo.sv
// Two-entry register queue used between stages and on the result side.
// Depends on nothing.
module gswu_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wptr, rptr;
  logic [1:0]       count;
  logic             do_push, do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= wdata;
  end

endmodule

### rtl/core/gswu_front.sv
// Front end: accepts items, classifies them and computes the spike delay.
// Depends on gswu_pkg and gswu_fifo.
module gswu_front #(
  parameter int NUM_SYNAPSES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          action,
  input  logic [7:0]          syn_index,
  input  logic signed [15:0]  theta,
  input  logic signed [31:0]  pre_spike_time,
  input  logic signed [31:0]  post_spike_time,
  input  logic [15:0]         load_weight,
  input  logic                hold,
  input  logic                item_pop,
  output gswu_pkg::item_t     item,
  output logic                item_empty
);

  gswu_pkg::item_t cls;
  logic            q_full;
  logic signed [32:0] post_ext, pre_ext;

  assign post_ext = 33'(post_spike_time);
  assign pre_ext  = 33'(pre_spike_time);
  assign full     = q_full | hold;

  // classify and precompute the delay in the direction the window wants
  always_comb begin
    cls.idx   = syn_index;
    cls.theta = theta;
    cls.dt    = post_ext - pre_ext;
    cls.load  = (load_weight > 16'(gswu_pkg::W_MAX)) ? 16'(gswu_pkg::W_MAX) : load_weight;
    if ({24'b0, syn_index} >= NUM_SYNAPSES) begin
      cls.op = gswu_pkg::OP_SKIP;
    end else begin
      case (action)
        gswu_pkg::ACT_LTP: begin
          cls.op = gswu_pkg::OP_LTP;
        end
        gswu_pkg::ACT_LTD: begin
          cls.op = gswu_pkg::OP_LTD;
          cls.dt = pre_ext - post_ext;
        end
        gswu_pkg::ACT_LOAD: begin
          cls.op = gswu_pkg::OP_LOAD;
        end
        default: begin
          cls.op = gswu_pkg::OP_KEEP;
        end
      endcase
    end
  end

  gswu_fifo #(.WIDTH($bits(gswu_pkg::item_t))) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full),
    .wdata (cls),
    .pop   (item_pop),
    .rdata (item),
    .full  (q_full),
    .empty (item_empty)
  );

endmodule

### rtl/core/gswu_exp.sv
// Three-stage Q16 exponential: base-2 conversion, table interpolation, shift.
// Depends on gswu_pkg.
module gswu_exp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [gswu_pkg::EXPY_W-1:0]  y,
  output logic                                done,
  output logic [gswu_pkg::EXPV_W-1:0]         value
);

  localparam logic signed [gswu_pkg::EXPY_W-1:0] YLIM = gswu_pkg::EXPY_W'(2097152);
  localparam logic signed [17:0] LOG2E = 18'sd94548;
  localparam logic [gswu_pkg::EXPV_W-1:0] CAP = {1'b1, 32'b0};

  logic signed [22:0] yc;
  logic signed [40:0] prod;
  logic signed [24:0] t1;
  logic               v1, v2;
  logic signed [8:0]  k, k2;
  logic [3:0]         fi;
  logic [11:0]        fr;
  logic [17:0]        t_lo, t_hi, diff, m_c, m2;
  logic [24:0]        interp;
  logic [32:0]        shl;
  logic [17:0]        shr;
  logic [4:0]         nk;
  logic [8:0]         negk;

  // clamp and convert to base 2
  always_comb begin
    if (y > YLIM) yc = 23'(YLIM);
    else if (y < -YLIM) yc = 23'(-YLIM);
    else yc = 23'(y);
  end
  assign prod = yc * LOG2E;

  // table interpolation of the fraction
  assign k      = t1[24:16];
  assign fi     = t1[15:12];
  assign fr     = t1[11:0];
  assign t_lo   = gswu_pkg::pow2_frac({1'b0, fi});
  assign t_hi   = gswu_pkg::pow2_frac({1'b0, fi} + 5'd1);
  assign diff   = t_hi - t_lo;
  assign interp = diff[12:0] * fr;
  assign m_c    = t_lo + 18'(interp[24:12]);

  // integer part as a shift
  assign negk = 9'(-k2);
  assign nk   = negk[4:0];
  assign shl  = {15'b0, m2} << k2[3:0];
  assign shr  = m2 >> nk;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    t1 <= prod[40:16];
    m2 <= m_c;
    k2 <= k;
    if (k2 >= 9'sd16) value <= CAP;
    else if (k2 <= -9'sd18) value <= '0;
    else if (k2 >= 9'sd0) value <= (shl > CAP) ? CAP : shl;
    else value <= {15'b0, shr};
  end

endmodule

### rtl/core/gswu_div.sv
// Restoring divider, one quotient bit a cycle, for the Gaussian argument sq*2^16/den.
// Depends on gswu_pkg. The caller guarantees the quotient fits Q_W bits.
module gswu_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [gswu_pkg::SQ_W-1:0]        sq,
  input  logic [gswu_pkg::DEN_W-1:0]       den,
  output logic                             done,
  output logic [gswu_pkg::Q_W-1:0]         q
);

  localparam logic [4:0] LAST = 5'(gswu_pkg::Q_W - 1);

  logic [32:0]                 rem;
  logic [gswu_pkg::Q_W-1:0]    nlow;
  logic [4:0]                  cnt;
  logic                        busy;
  logic [33:0]                 r2;
  logic                        ge;
  logic [33:0]                 rsub;

  // one trial subtraction
  assign r2   = {rem, nlow[gswu_pkg::Q_W-1]};
  assign ge   = (r2 >= {1'b0, den});
  assign rsub = r2 - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= sq[37:5];
      nlow <= {sq[4:0], 16'b0};
    end else if (busy) begin
      rem  <= ge ? rsub[32:0] : r2[32:0];
      nlow <= nlow << 1;
      q    <= {q[gswu_pkg::Q_W-2:0], ge};
    end
  end

endmodule

### rtl/core/gswu_back.sv
// Back end: weight memory, update sequencer, running total and reset clearing pass.
// Depends on gswu_pkg, gswu_exp and gswu_div.
module gswu_back #(
  parameter int NUM_SYNAPSES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  gswu_pkg::cfg_t   cfg,
  input  gswu_pkg::item_t  item,
  input  logic             item_empty,
  output logic             item_pop,
  input  logic             res_full,
  output logic             res_push,
  output gswu_pkg::res_t   res,
  output logic             clearing
);

  localparam int AW = $clog2(NUM_SYNAPSES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SYNAPSES - 1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_DISP  = 4'd3;
  localparam logic [3:0] ST_AMP   = 4'd4;
  localparam logic [3:0] ST_AMPW  = 4'd5;
  localparam logic [3:0] ST_GCHK  = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_GEXP  = 4'd8;
  localparam logic [3:0] ST_PROD1 = 4'd9;
  localparam logic [3:0] ST_PROD2 = 4'd10;
  localparam logic [3:0] ST_PROD3 = 4'd11;
  localparam logic [3:0] ST_WRITE = 4'd12;

  logic [3:0]      state, state_next;
  logic [AW-1:0]   clr_cnt;
  gswu_pkg::item_t item_q;
  logic [15:0]     weights [NUM_SYNAPSES];
  logic [15:0]     rdata, oldw;
  logic [AW-1:0]   addr;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [15:0]     mem_wd;

  logic signed [32:0] prod_rt;
  logic [24:0]        ad_q;
  logic [49:0]        sq_q;
  logic [32:0]        den_q;
  logic signed [34:0] amp_q;
  logic [16:0]        g_q;
  logic signed [42:0] p_q;
  logic [36:0]        pp_lo_q;
  logic signed [40:0] pp_hi_q;
  logic signed [38:0] delta_q;
  logic [23:0]        total, total_next;

  logic               is_ltp;
  logic [15:0]        mu, wd, rate, gain, sg;
  logic signed [33:0] dval;
  logic [33:0]        adabs;
  logic [24:0]        ad_c;
  logic signed [25:0] sh26, ya, yg, exp_y;
  logic               exp_start, exp_done, div_start, div_done;
  logic [32:0]        exp_v;
  logic [20:0]        div_q;
  logic               g_zero;
  logic signed [34:0] amp_c;
  logic signed [50:0] gp;
  logic [36:0]        pp_lo_c;
  logic signed [40:0] pp_hi_c;
  logic signed [61:0] sum_c;
  logic signed [39:0] sumw;
  logic [15:0]        neww;
  logic [31:0]        sgsq;

  // per-action parameter selection
  assign is_ltp = (item_q.op == gswu_pkg::OP_LTP);
  assign mu     = is_ltp ? cfg.ltp_mean  : cfg.ltd_mean;
  assign wd     = is_ltp ? cfg.ltp_width : cfg.ltd_width;
  assign rate   = is_ltp ? cfg.ltp_rate  : cfg.ltd_rate;
  assign gain   = is_ltp ? cfg.ltp_gain  : cfg.ltd_gain;
  assign sg     = (wd == 16'd0) ? 16'd1 : wd;
  assign sgsq   = sg * sg;

  // distance from the window center, clamped
  assign dval  = $signed({18'b0, mu}) - item_q.dt;
  assign adabs = dval[33] ? 34'(-dval) : 34'(dval);
  assign ad_c  = (adabs > 34'd16777216) ? 25'd16777216 : adabs[24:0];

  // exponent arguments
  assign sh26  = 26'($signed(prod_rt[32:8]));
  assign ya    = -sh26;
  assign yg    = -$signed({5'b0, div_q});
  assign exp_y = (state == ST_AMP) ? ya : yg;

  assign exp_start = (state == ST_AMP) || (state == ST_DIV && div_done);
  assign g_zero    = item_q.dt[32] || (sq_q >= {12'b0, den_q, 5'b0});
  assign div_start = (state == ST_GCHK) && !g_zero;

  // amplitude and delta arithmetic
  assign amp_c   = is_ltp ? ($signed(35'd131072) - $signed({2'b0, exp_v}))
                          : -$signed({2'b0, exp_v});
  assign gp      = $signed(gain) * amp_q;
  assign pp_lo_c = p_q[19:0] * g_q;
  assign pp_hi_c = $signed(p_q[42:20]) * $signed({1'b0, g_q});
  assign sum_c   = $signed({pp_hi_q, 20'b0}) + $signed({25'b0, pp_lo_q});
  assign sumw    = $signed({24'b0, oldw}) + delta_q;

  // new weight and total
  always_comb begin
    case (item_q.op)
      gswu_pkg::OP_LTP, gswu_pkg::OP_LTD: begin
        if (sumw < 40'sd0) neww = 16'd0;
        else if (sumw > 40'(gswu_pkg::W_MAX)) neww = 16'(gswu_pkg::W_MAX);
        else neww = sumw[15:0];
      end
      gswu_pkg::OP_LOAD: neww = item_q.load;
      gswu_pkg::OP_KEEP: neww = oldw;
      default: neww = 16'd0;
    endcase
    if (item_q.op == gswu_pkg::OP_SKIP) total_next = total;
    else total_next = total - 24'(oldw) + 24'(neww);
  end

  assign item_pop = (state == ST_IDLE) && !item_empty && !res_full;
  assign res_push = (state == ST_WRITE);
  assign res      = '{idx: item_q.idx, weight: neww, total: total_next};
  assign clearing = (state == ST_CLEAR);

  // memory port selection
  assign addr   = AW'(item_q.idx);
  assign mem_we = clearing || (state == ST_WRITE && item_q.op != gswu_pkg::OP_SKIP);
  assign mem_wa = clearing ? clr_cnt : addr;
  assign mem_wd = clearing ? 16'd0 : neww;

  always_ff @(posedge clk) begin
    if (mem_we) weights[mem_wa] <= mem_wd;
    rdata <= weights[addr];
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE:  if (item_pop) state_next = ST_READ;
      ST_READ:  state_next = ST_DISP;
      ST_DISP: begin
        if (item_q.op == gswu_pkg::OP_LTP || item_q.op == gswu_pkg::OP_LTD)
          state_next = ST_AMP;
        else
          state_next = ST_WRITE;
      end
      ST_AMP:   state_next = ST_AMPW;
      ST_AMPW:  if (exp_done) state_next = ST_GCHK;
      ST_GCHK:  state_next = g_zero ? ST_PROD1 : ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_GEXP;
      ST_GEXP:  if (exp_done) state_next = ST_PROD1;
      ST_PROD1: state_next = ST_PROD2;
      ST_PROD2: state_next = ST_PROD3;
      ST_PROD3: state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      total   <= 24'd0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + AW'(1);
      if (res_push) total <= total_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (item_pop) item_q <= item;
    case (state)
      ST_DISP: begin
        oldw    <= rdata;
        prod_rt <= $signed({1'b0, rate}) * item_q.theta;
        ad_q    <= ad_c;
      end
      ST_AMP: begin
        sq_q  <= ad_q * ad_q;
        den_q <= {sgsq, 1'b0};
      end
      ST_AMPW:  if (exp_done) amp_q <= amp_c;
      ST_GCHK:  if (g_zero) g_q <= 17'd0;
      ST_GEXP:  if (exp_done) g_q <= exp_v[16:0];
      ST_PROD1: p_q <= gp[50:8];
      ST_PROD2: begin
        pp_lo_q <= pp_lo_c;
        pp_hi_q <= pp_hi_c;
      end
      ST_PROD3: delta_q <= sum_c[61:23];
      default: ;
    endcase
  end

  gswu_exp u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .y     (exp_y),
    .done  (exp_done),
    .value (exp_v)
  );

  gswu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sq    (sq_q[37:0]),
    .den   (den_q),
    .done  (div_done),
    .q     (div_q)
  );

  // checks
  a_push_room: assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result pushed into a full queue");
  a_exp_wait: assert property (@(posedge clk) disable iff (rst)
    exp_done |-> (state == ST_AMPW || state == ST_GEXP))
    else $error("exponential finished outside a wait state");
  a_div_wait: assert property (@(posedge clk) disable iff (rst) div_done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");
  a_bound: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res.weight <= 16'(gswu_pkg::W_MAX))
    else $error("weight above upper bound");

endmodule

### rtl/core/gaussian_stdp_weight_update_core.sv
// Gaussian-window STDP weight update core, top level.
// Potentiate/depress items pass twice through the 3-stage exponential unit and once through
// the divider; when the timing factor is zero the second exponential pass and the divider
// are skipped. Load and no-op items use neither unit. One item is in the back end at a time,
// so the back end takes no new item before the last one is written. After reset a clearing
// pass zeroes the weight memory with full held high. Depends on gswu_pkg, gswu_front, gswu_back, gswu_fifo.
module gaussian_stdp_weight_update_core #(
  parameter int NUM_SYNAPSES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action,
  input  logic [7:0]         syn_index,
  input  logic signed [15:0] theta,
  input  logic signed [31:0] pre_spike_time,
  input  logic signed [31:0] post_spike_time,
  input  logic [15:0]        load_weight,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_index,
  output logic [15:0]        new_weight,
  output logic [23:0]        total_weight,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  gswu_pkg::cfg_t  cfg;
  gswu_pkg::item_t item;
  gswu_pkg::res_t  res, res_out;
  logic            item_empty, item_pop, res_full, res_push, clearing;
  logic            wr_en;
  logic [15:0]     rd_sel;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{ltp_mean: 16'd160, ltp_width: 16'd80, ltp_rate: 16'd4096,
               ltd_mean: 16'd160, ltd_width: 16'd80, ltd_rate: 16'd4096,
               ltp_gain: 16'd82, ltd_gain: 16'd82};
    end else if (wr_en) begin
      case (paddr[4:2])
        gswu_pkg::REG_LTP_MEAN:  cfg.ltp_mean  <= pwdata[15:0];
        gswu_pkg::REG_LTP_WIDTH: cfg.ltp_width <= pwdata[15:0];
        gswu_pkg::REG_LTP_RATE:  cfg.ltp_rate  <= pwdata[15:0];
        gswu_pkg::REG_LTD_MEAN:  cfg.ltd_mean  <= pwdata[15:0];
        gswu_pkg::REG_LTD_WIDTH: cfg.ltd_width <= pwdata[15:0];
        gswu_pkg::REG_LTD_RATE:  cfg.ltd_rate  <= pwdata[15:0];
        gswu_pkg::REG_LTP_GAIN:  cfg.ltp_gain  <= pwdata[15:0];
        gswu_pkg::REG_LTD_GAIN:  cfg.ltd_gain  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[4:2])
      gswu_pkg::REG_LTP_MEAN:  rd_sel = cfg.ltp_mean;
      gswu_pkg::REG_LTP_WIDTH: rd_sel = cfg.ltp_width;
      gswu_pkg::REG_LTP_RATE:  rd_sel = cfg.ltp_rate;
      gswu_pkg::REG_LTD_MEAN:  rd_sel = cfg.ltd_mean;
      gswu_pkg::REG_LTD_WIDTH: rd_sel = cfg.ltd_width;
      gswu_pkg::REG_LTD_RATE:  rd_sel = cfg.ltd_rate;
      gswu_pkg::REG_LTP_GAIN:  rd_sel = cfg.ltp_gain;
      gswu_pkg::REG_LTD_GAIN:  rd_sel = cfg.ltd_gain;
      default:                 rd_sel = 16'd0;
    endcase
  end
  assign prdata = {16'b0, rd_sel};

  gswu_front #(.NUM_SYNAPSES(NUM_SYNAPSES)) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .action          (action),
    .syn_index       (syn_index),
    .theta           (theta),
    .pre_spike_time  (pre_spike_time),
    .post_spike_time (post_spike_time),
    .load_weight     (load_weight),
    .hold            (clearing),
    .item_pop        (item_pop),
    .item            (item),
    .item_empty      (item_empty)
  );

  gswu_back #(.NUM_SYNAPSES(NUM_SYNAPSES)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res),
    .clearing   (clearing)
  );

  // result queue
  gswu_fifo #(.WIDTH($bits(gswu_pkg::res_t))) u_results (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .pop   (pop),
    .rdata (res_out),
    .full  (res_full),
    .empty (empty)
  );

  assign out_index    = res_out.idx;
  assign new_weight   = res_out.weight;
  assign total_weight = res_out.total;

endmodule

### dv/tb.sv
// Self-checking testbench for gaussian_stdp_weight_update_core: directed table, then random
// potentiate/depress/load/no-op items over several register settings. Depends on gswu_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_REGS      = 8;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int NSYN = 256;
  localparam int SETTLE = 60;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_PER_PHASE = 75;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] action = '0;
  logic [7:0] syn_index = '0;
  logic signed [15:0] theta = '0;
  logic signed [31:0] pre_spike_time = '0;
  logic signed [31:0] post_spike_time = '0;
  logic [15:0] load_weight = '0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_index;
  logic [15:0] new_weight;
  logic [23:0] total_weight;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gaussian_stdp_weight_update_core #(.NUM_SYNAPSES(NSYN)) i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .syn_index(syn_index), .theta(theta), .pre_spike_time(pre_spike_time),
    .post_spike_time(post_spike_time), .load_weight(load_weight), .empty(empty),
    .pop(pop), .out_index(out_index), .new_weight(new_weight),
    .total_weight(total_weight), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus row; typed rows carry a hand-derived weight and total
  typedef struct {
    logic [1:0]         act;
    logic [7:0]         idx;
    logic signed [15:0] th;
    logic signed [31:0] pre;
    logic signed [31:0] post;
    logic [15:0]        ld;
    bit                 typed;
    logic [15:0]        w;
    logic [23:0]        t;
  } stim_t;

  // shadow state of the block
  logic [15:0]     cfg_shadow [NUM_REGS];
  logic [15:0]     weight_mem [NSYN];
  logic [23:0]     weight_sum;
  gswu_pkg::res_t  pending_updates[$];
  int              errors = 0;
  int              items_sent = 0;
  int              results_seen = 0;
  longint          cycles = 0;

  // 2^(j/16) in Q16
  const longint frac_tab [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
    92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};

  // exp(y), y and result in Q16
  function automatic longint exp_fx(longint y);
    longint t, k, m, f, i, fr;
    if (y > 32 * 65536) y = 32 * 65536;
    if (y < -32 * 65536) y = -32 * 65536;
    t = (y * 64'sd94548) >>> 16;
    k = t >>> 16;
    f = t - k * 65536;
    if (k >= 16) return 64'sd4294967296;
    if (k <= -18) return 0;
    i = f >>> 12;
    fr = f & 4095;
    m = frac_tab[i] + (((frac_tab[i + 1] - frac_tab[i]) * fr) >>> 12);
    if (k >= 0) m = m <<< k;
    else m = m >>> (-k);
    return (m > 64'sd4294967296) ? 64'sd4294967296 : m;
  endfunction

  // Gaussian timing window in Q16
  function automatic longint window_fx(logic [15:0] mu, logic [15:0] sig, longint dt);
    longint d, sg, den, sq;
    if (dt < 0) return 0;
    d = longint'(mu) - dt;
    if (d < 0) d = -d;
    if (d > (64'sd1 << 24)) d = 64'sd1 << 24;
    sg = (sig == 0) ? 1 : longint'(sig);
    den = 2 * sg * sg;
    sq = d * d;
    if (sq >= 32 * den) return 0;
    return exp_fx(-((sq <<< 16) / den));
  endfunction

  // weight change in Q1.14
  function automatic longint delta_fx(logic signed [15:0] gain, longint amp, longint g);
    longint p;
    p = (longint'(gain) * amp) >>> 8;
    return (p * g) >>> 23;
  endfunction

  // next weight and total for one accepted item
  function automatic gswu_pkg::res_t update_weight(stim_t s);
    gswu_pkg::res_t r;
    longint oldw, neww, amp, g, dt;
    oldw = weight_mem[s.idx];
    neww = oldw;
    dt = longint'(s.post) - longint'(s.pre);
    case (s.act)
      gswu_pkg::ACT_LTP: begin
        amp = 2 * 65536 -
              exp_fx(-((longint'(cfg_shadow[gswu_pkg::REG_LTP_RATE]) * s.th) >>> 8));
        g = window_fx(cfg_shadow[gswu_pkg::REG_LTP_MEAN],
                      cfg_shadow[gswu_pkg::REG_LTP_WIDTH], dt);
        neww = oldw + delta_fx(cfg_shadow[gswu_pkg::REG_LTP_GAIN], amp, g);
      end
      gswu_pkg::ACT_LTD: begin
        amp = -exp_fx(-((longint'(cfg_shadow[gswu_pkg::REG_LTD_RATE]) * s.th) >>> 8));
        g = window_fx(cfg_shadow[gswu_pkg::REG_LTD_MEAN],
                      cfg_shadow[gswu_pkg::REG_LTD_WIDTH], -dt);
        neww = oldw + delta_fx(cfg_shadow[gswu_pkg::REG_LTD_GAIN], amp, g);
      end
      gswu_pkg::ACT_LOAD: neww = longint'(s.ld);
      default: ;
    endcase
    if (neww < 0) neww = 0;
    if (neww > gswu_pkg::W_MAX) neww = gswu_pkg::W_MAX;
    weight_mem[s.idx] = neww[15:0];
    weight_sum = weight_sum - oldw[23:0] + neww[23:0];
    r.idx = s.idx;
    r.weight = neww[15:0];
    r.total = weight_sum;
    return r;
  endfunction

  // random gap: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d updates outstanding", $time, pending_updates.size());
      $display("tb: errors");
      $finish;
    end
  end

  // result side: sample at the falling edge, take at the rising edge
  initial begin : result_side
    logic e, p;
    gswu_pkg::res_t got, want;
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      e = empty;
      p = pop;
      got.idx = out_index;
      got.weight = new_weight;
      got.total = total_weight;
      @(posedge clk);
      if (p && !e) begin
        results_seen++;
        if (pending_updates.size() == 0) begin
          $display("%0t unexpected update idx=%0d weight=%0d total=%0d", $time,
                   got.idx, got.weight, got.total);
          errors++;
        end else begin
          want = pending_updates.pop_front();
          if (got.idx !== want.idx) begin
            $display("%0t out_index exp %0d got %0d", $time, want.idx, got.idx);
            errors++;
          end
          if (got.weight !== want.weight) begin
            $display("%0t new_weight exp %0d got %0d", $time, want.weight, got.weight);
            errors++;
          end
          if (got.total !== want.total) begin
            $display("%0t total_weight exp %0d got %0d", $time, want.total, got.total);
            errors++;
          end
        end
      end
      // stalls of random length
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        stall = gap_len();
        pop <= (stall == 0);
      end
    end
  end

  // register write: setup then access
  task automatic write_reg(int idx, logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(4 * idx);
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_shadow[idx] = val;
  endtask

  // wait for all updates, then let the back end settle
  task automatic drain();
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // hold push high across back-to-back items; wait for acceptance
  task automatic send_item(stim_t s);
    logic f;
    gswu_pkg::res_t r;
    int gap;
    push <= 1'b1;
    action <= s.act;
    syn_index <= s.idx;
    theta <= s.th;
    pre_spike_time <= s.pre;
    post_spike_time <= s.post;
    load_weight <= s.ld;
    do begin
      @(negedge clk);
      f = full;
      @(posedge clk);
    end while (f);
    r = update_weight(s);
    if (s.typed) begin
      r.weight = s.w;
      r.total = s.t;
    end
    pending_updates.push_back(r);
    items_sent++;
    gap = gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic stim_t row(logic [1:0] a, logic [7:0] i, logic signed [15:0] th,
                                logic signed [31:0] pr, logic signed [31:0] po,
                                logic [15:0] ld, bit ty = 0, logic [15:0] w = 0,
                                logic [23:0] t = 0);
    stim_t s;
    s.act = a; s.idx = i; s.th = th; s.pre = pr; s.post = po; s.ld = ld;
    s.typed = ty; s.w = w; s.t = t;
    return s;
  endfunction

  // random item: mostly spike pairs near the window center
  function automatic stim_t random_item();
    stim_t s;
    longint w, off, base, mu;
    int r;
    r = $urandom_range(0, 99);
    s.act = (r < 40) ? gswu_pkg::ACT_LTP : (r < 80) ? gswu_pkg::ACT_LTD :
            (r < 94) ? gswu_pkg::ACT_LOAD : ACT_NONE;
    s.idx = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    s.th = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16384) - 8192);
    s.ld = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                       : 16'($urandom_range(0, gswu_pkg::W_MAX));
    s.typed = 0; s.w = 0; s.t = 0;
    if ($urandom_range(0, 4) == 0) begin
      s.pre = $urandom;
      s.post = $urandom;
    end else begin
      if (s.act == gswu_pkg::ACT_LTD) begin
        mu = cfg_shadow[gswu_pkg::REG_LTD_MEAN];
        w = (cfg_shadow[gswu_pkg::REG_LTD_WIDTH] == 0) ? 1 :
            cfg_shadow[gswu_pkg::REG_LTD_WIDTH];
      end else begin
        mu = cfg_shadow[gswu_pkg::REG_LTP_MEAN];
        w = (cfg_shadow[gswu_pkg::REG_LTP_WIDTH] == 0) ? 1 :
            cfg_shadow[gswu_pkg::REG_LTP_WIDTH];
      end
      off = longint'($urandom_range(0, 8 * w)) - 4 * w;
      base = longint'($urandom_range(0, 32'h3FFF_FFFF)) - 64'sd536870912;
      s.pre = base[31:0];
      s.post = 32'(base + mu + off);
      if (s.act == gswu_pkg::ACT_LTD) begin
        s.post = base[31:0];
        s.pre = 32'(base + mu + off);
      end
    end
    return s;
  endfunction

  initial begin : stimulus
    stim_t table_rows[$];
    logic [15:0] settings [4][NUM_REGS];
    int ph, k;
    cfg_shadow = '{16'd160, 16'd80, 16'd4096, 16'd160, 16'd80, 16'd4096, 16'd82, 16'd82};
    foreach (weight_mem[j]) weight_mem[j] = '0;
    weight_sum = '0;

    // register settings: zero widths and means, all ones, random, moderate
    settings[0] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h8000};
    settings[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'h8000, 16'h7FFF};
    for (k = 0; k < NUM_REGS; k++) settings[2][k] = 16'($urandom);
    settings[3] = '{16'd100, 16'd50, 16'd4096, 16'd100, 16'd50, 16'd2048, 16'd3000, 16'd3000};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: load extremes, unused action, negative delays, theta and time extremes
    table_rows.push_back(row(gswu_pkg::ACT_LOAD, 8'd0, 0, 0, 0, 16'd32768, 1, 16'd32768,
                             24'd32768));
    table_rows.push_back(row(gswu_pkg::ACT_LOAD, 8'd255, 0, 0, 0, 16'hFFFF, 1, 16'd32768,
                             24'd65536));
    table_rows.push_back(row(gswu_pkg::ACT_LOAD, 8'd1, 0, 0, 0, 16'd0, 1, 16'd0, 24'd65536));
    table_rows.push_back(row(ACT_NONE, 8'd0, 0, 0, 0, 16'd0, 1, 16'd32768, 24'd65536));
    table_rows.push_back(row(gswu_pkg::ACT_LTP, 8'd1, 0, 100, 50, 0, 1, 16'd0, 24'd65536));
    table_rows.push_back(row(gswu_pkg::ACT_LTD, 8'd0, 0, 0, 10, 0, 1, 16'd32768, 24'd65536));
    table_rows.push_back(row(gswu_pkg::ACT_LTP, 8'd1, 0, 0, 160, 0));
    table_rows.push_back(row(gswu_pkg::ACT_LTP, 8'd1, 16'sh7FFF, 0, 160, 0));
    table_rows.push_back(row(gswu_pkg::ACT_LTP, 8'd1, -16'sh8000, 0, 150, 0));
    table_rows.push_back(row(gswu_pkg::ACT_LTD, 8'd0, 0, 160, 0, 0));
    table_rows.push_back(row(gswu_pkg::ACT_LTD, 8'd0, -16'sh8000, 170, 0, 0));
    table_rows.push_back(row(gswu_pkg::ACT_LTD, 8'd0, 16'sh7FFF, 160, 0, 0));
    table_rows.push_back(row(gswu_pkg::ACT_LTP, 8'd2, 16'sh1000, 32'sh8000_0000,
                             32'sh7FFF_FFFF, 0));
    table_rows.push_back(row(gswu_pkg::ACT_LTD, 8'd3, 16'sh1000, 32'sh7FFF_FFFF,
                             32'sh8000_0000, 0));
    table_rows.push_back(row(gswu_pkg::ACT_LOAD, 8'd128, 0, 0, 0, 16'd16384));
    table_rows.push_back(row(gswu_pkg::ACT_LTP, 8'd128, 16'sh1000, -32'sd1000, -32'sd840, 0));
    table_rows.push_back(row(gswu_pkg::ACT_LTD, 8'd128, 16'sh1000, -32'sd840, -32'sd1000, 0));
    table_rows.push_back(row(gswu_pkg::ACT_LOAD, 8'd170, 0, 0, 0, 16'h5555));
    table_rows.push_back(row(gswu_pkg::ACT_LOAD, 8'd85, 0, 0, 0, 16'hAAAA));
    foreach (table_rows[j]) send_item(table_rows[j]);
    push <= 1'b0;
    drain();

    // random items under each register setting, reset values first
    for (ph = -1; ph < 4; ph++) begin
      if (ph >= 0) begin
        for (k = 0; k < NUM_REGS; k++) write_reg(k, settings[ph][k]);
      end
      repeat (RAND_PER_PHASE) send_item(random_item());
      push <= 1'b0;
      drain();
    end

    $display("tb: %0d items sent, %0d updates checked, 5 register settings incl. extremes",
             items_sent, results_seen);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/gswu_pkg.sv
rtl/core/gswu_fifo.sv
rtl/core/gswu_front.sv
rtl/core/gswu_exp.sv
rtl/core/gswu_div.sv
rtl/core/gswu_back.sv
rtl/core/gaussian_stdp_weight_update_core.sv
dv/tb.sv
